### sv/bsbc_pkg.sv
`default_nettype none
package bsbc_pkg;

    localparam int NUM_ROUNDS = 14;
    localparam int STEP_W     = 4;

    typedef logic [31:0]            t_row;
    typedef logic [0:3][31:0]       t_state;
    typedef t_state [0:NUM_ROUNDS]  t_rkeys;
    typedef logic [3:0]             t_nib;

    typedef enum logic {
        CMD_ENC = 1'b0,
        CMD_DEC = 1'b1
    } t_cmd;

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    typedef struct packed {
        logic              busy;
        logic [STEP_W-1:0] step;
    } t_ks_status;

    localparam t_nib SBOX_FW [16] = '{
        4'h2, 4'hd, 4'h3, 4'h9, 4'h7, 4'hb, 4'ha, 4'h6,
        4'he, 4'h0, 4'hf, 4'h4, 4'h8, 4'h5, 4'h1, 4'hc
    };
    localparam t_nib SBOX_BW [16] = '{
        4'h9, 4'he, 4'h0, 4'h2, 4'hb, 4'hd, 4'h7, 4'h4,
        4'hc, 4'h3, 4'h6, 4'h5, 4'hf, 4'h1, 4'h8, 4'ha
    };

    localparam t_state ROW_MAT_FW = {32'ha3861085, 32'h63417021, 32'h692cf280, 32'h48a54813};
    localparam t_state ROW_MAT_BW = {32'h2037a121, 32'h108ff2a0, 32'h9054d8c0, 32'h3354b117};
    localparam t_row   KEY_MAT    = 32'hb881b9ca;
    localparam t_state KEY_CONST  = {32'h00000080, 32'h00006a00, 32'h003f0000, 32'h24000000};

    // circulant matrix given by its column, times a vector
    function automatic t_row circ_mul(t_row col, t_row vec);
        t_row        acc;
        logic [63:0] dbl;
        logic [63:0] sh;
        acc = '0;
        dbl = {col, col};
        for (int i = 0; i < 32; i++) begin
            sh = dbl >> (31 - i);
            if (vec[i]) begin
                acc = acc ^ sh[31:0];
            end
        end
        return acc;
    endfunction

    function automatic t_row rotl(t_row x, int n);
        logic [63:0] dbl;
        dbl = {x, x} << n;
        return dbl[63:32];
    endfunction

    // row 0 carries the top bit of each column nibble
    function automatic t_state sub_cols(t_state s, logic inv);
        t_state o;
        t_nib   nib;
        t_nib   sb;
        for (int b = 0; b < 32; b++) begin
            nib = {s[0][b], s[1][b], s[2][b], s[3][b]};
            sb  = inv ? SBOX_BW[nib] : SBOX_FW[nib];
            o[0][b] = sb[3];
            o[1][b] = sb[2];
            o[2][b] = sb[1];
            o[3][b] = sb[0];
        end
        return o;
    endfunction

    function automatic t_state mix_rows(t_state s, logic inv);
        t_state o;
        for (int r = 0; r < 4; r++) begin
            o[r] = circ_mul(inv ? ROW_MAT_BW[r] : ROW_MAT_FW[r], s[r]);
        end
        return o;
    endfunction

    function automatic t_state key_next(t_state k, logic [STEP_W-1:0] step);
        t_row   all;
        t_state t;
        all  = k[0] ^ k[1] ^ k[2] ^ k[3];
        t[0] = circ_mul(KEY_MAT, k[0] ^ all);
        t[1] = rotl(k[1] ^ all, 8);
        t[2] = rotl(k[2] ^ all, 15);
        t[3] = rotl(k[3] ^ all, 18);
        t    = t ^ KEY_CONST;
        t[0] = t[0] ^ 32'(step);
        return t;
    endfunction

endpackage
`default_nettype wire

### sv/bsbc_round.sv
`default_nettype none
module bsbc_round (
    input  wire  bsbc_pkg::t_state i_state,
    input  wire                    i_dec,
    input  wire  bsbc_pkg::t_state i_key_fw,
    input  wire  bsbc_pkg::t_state i_key_bw,
    input  wire  bsbc_pkg::t_state i_key_post,
    output bsbc_pkg::t_state       o_state
);

    bsbc_pkg::t_state w_fw;
    bsbc_pkg::t_state w_bw;

    assign w_fw = bsbc_pkg::mix_rows(bsbc_pkg::sub_cols(i_state ^ i_key_fw, 1'b0), 1'b0)
                  ^ i_key_post;
    assign w_bw = bsbc_pkg::sub_cols(bsbc_pkg::mix_rows(i_state, 1'b1), 1'b1) ^ i_key_bw;

    assign o_state = i_dec ? w_bw : w_fw;

endmodule
`default_nettype wire

### sv/bsbc_keysched.sv
`default_nettype none
module bsbc_keysched (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire                        i_cfg_idx,
    input  wire  [63:0]                i_cfg_data,
    output bsbc_pkg::t_rkeys           o_rkeys,
    output bsbc_pkg::t_ks_status       o_status
);

    logic [63:0]                       r_key_high;
    logic [63:0]                       r_key_low;
    logic [63:0]                       n_key_high;
    logic [63:0]                       n_key_low;
    bsbc_pkg::t_state                  r_kw;
    bsbc_pkg::t_state                  w_kw_next;
    logic [bsbc_pkg::STEP_W-1:0]       r_step;
    logic                              r_busy;
    bsbc_pkg::t_state [1:bsbc_pkg::NUM_ROUNDS] r_rk;

    assign n_key_high = (i_cfg_we && i_cfg_idx == bsbc_pkg::REG_KEY_HIGH) ? i_cfg_data
                                                                           : r_key_high;
    assign n_key_low  = (i_cfg_we && i_cfg_idx == bsbc_pkg::REG_KEY_LOW) ? i_cfg_data
                                                                          : r_key_low;
    assign w_kw_next  = bsbc_pkg::key_next(r_kw, r_step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_kw       <= '0;
            r_step     <= '0;
            r_busy     <= 1'b1;
        end else begin
            r_key_high <= n_key_high;
            r_key_low  <= n_key_low;
            if (i_cfg_we) begin
                r_kw   <= {n_key_high, n_key_low};
                r_step <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_kw   <= w_kw_next;
                r_step <= r_step + bsbc_pkg::STEP_W'(1);
                r_busy <= (r_step != bsbc_pkg::STEP_W'(bsbc_pkg::NUM_ROUNDS - 1));
            end
        end
    end

    // one round key per cycle while the expansion is busy; a key write restarts it
    for (genvar j = 1; j <= bsbc_pkg::NUM_ROUNDS; j++) begin : g_rk
        always_ff @(posedge i_clk) begin
            if (r_busy && !i_cfg_we && r_step == bsbc_pkg::STEP_W'(j - 1)) begin
                r_rk[j] <= w_kw_next;
            end
        end
        assign o_rkeys[j] = r_rk[j];
    end

    assign o_rkeys[0]    = {r_key_high, r_key_low};
    assign o_status.busy = r_busy;
    assign o_status.step = r_step;

endmodule
`default_nettype wire

### sv/bitsliced_spn_block_cipher_128.sv
// an accepted word passes the input register and the round registers to the output
// throughput: one word per cycle, one round per pipeline stage, stalls hold every stage
// reset (synchronous, active low) clears the pipeline and the key, then runs the
// round key expansion; any key write restarts it, tready stays low meanwhile
`default_nettype none
module bitsliced_spn_block_cipher_128 (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [127:0] i_s_axis_tdata,   // block_low, block_high
    input  wire          i_s_axis_tuser,   // command
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // result_low, result_high
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire  [63:0]  i_cfg_data
);

    localparam int NR = bsbc_pkg::NUM_ROUNDS;

    bsbc_pkg::t_rkeys            w_rkeys;
    bsbc_pkg::t_ks_status        w_ks;
    logic                        w_adv;
    logic                        w_acc;
    logic                        w_in_dec;
    bsbc_pkg::t_state            w_in;
    logic [0:NR]                 r_vld;
    logic [0:NR-1]               r_dec;
    bsbc_pkg::t_state [0:NR]     r_st;
    bsbc_pkg::t_state [0:NR-1]   w_rnd;

    bsbc_keysched u_keysched (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_rkeys    (w_rkeys),
        .o_status   (w_ks)
    );

    assign w_adv           = !r_vld[NR] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv && !w_ks.busy;
    assign w_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_dec        = (i_s_axis_tuser == bsbc_pkg::CMD_DEC);
    assign w_in            = {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {w_acc, r_vld[0:NR-1]};
        end
    end

    // decryption starts with the last round key
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_st[0]  <= w_in ^ (w_in_dec ? w_rkeys[NR] : '0);
            r_dec[0] <= w_in_dec;
        end
    end

    for (genvar j = 0; j < NR; j++) begin : g_round
        if (j == NR - 1) begin : g_last
            bsbc_round u_round (
                .i_state    (r_st[j]),
                .i_dec      (r_dec[j]),
                .i_key_fw   (w_rkeys[j]),
                .i_key_bw   (w_rkeys[NR-1-j]),
                .i_key_post (w_rkeys[NR]),
                .o_state    (w_rnd[j])
            );
        end else begin : g_mid
            bsbc_round u_round (
                .i_state    (r_st[j]),
                .i_dec      (r_dec[j]),
                .i_key_fw   (w_rkeys[j]),
                .i_key_bw   (w_rkeys[NR-1-j]),
                .i_key_post ('0),
                .o_state    (w_rnd[j])
            );

            always_ff @(posedge i_clk) begin
                if (w_adv) begin
                    r_dec[j+1] <= r_dec[j];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_st[j+1] <= w_rnd[j];
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[NR];
    assign o_m_axis_tdata  = {r_st[NR][2], r_st[NR][3], r_st[NR][0], r_st[NR][1]};

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ks.busy |-> (w_ks.step <= bsbc_pkg::STEP_W'(NR - 1)))
        else $error("key expansion step out of range");

    a_cfg_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (w_ks.busy && w_ks.step == '0))
        else $error("key write did not restart expansion");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_vld[NR-1]))
        else $error("result word appeared without a word in the last round");

endmodule
`default_nettype wire

### sim/cipher_checker.sv
`timescale 1ns / 100ps
module cipher_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    input  wire  [127:0] i_s_tdata,
    input  wire          i_s_tuser,
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    input  wire  [127:0] i_m_tdata,
    input  wire          i_cfg_we,
    input  wire          i_cfg_idx,
    input  wire  [63:0]  i_cfg_data,
    output int           o_fail_count,
    output int           o_pending
);

    typedef logic [0:3][31:0] t_rows;

    // nibble tables, entry 0 in the lowest bits
    localparam logic [63:0] SUB_FWD = 64'hc158_4f0e_6ab7_93d2;
    localparam logic [63:0] SUB_INV = 64'ha81f_563c_47db_20e9;
    localparam t_rows MIX_FWD = {32'ha3861085, 32'h63417021, 32'h692cf280, 32'h48a54813};
    localparam t_rows MIX_INV = {32'h2037a121, 32'h108ff2a0, 32'h9054d8c0, 32'h3354b117};
    localparam t_rows KEY_ADD = {32'h00000080, 32'h00006a00, 32'h003f0000, 32'h24000000};
    localparam logic [31:0] KEY_COL = 32'hb881b9ca;
    localparam int ROUNDS = 14;

    logic [63:0]  key_hi;
    logic [63:0]  key_lo;
    logic [127:0] cipher_out_q [$];
    logic [127:0] want;
    int           fail_count;

    assign o_fail_count = fail_count;

    function automatic logic [31:0] circ(input logic [31:0] col, input logic [31:0] v);
        logic [31:0] acc;
        logic [31:0] c;
        acc = '0;
        c   = col;
        for (int b = 31; b >= 0; b--) begin
            if (v[b]) begin
                acc = acc ^ c;
            end
            c = {c[0], c[31:1]};
        end
        return acc;
    endfunction

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    // row 0 is the top bit of each column nibble
    function automatic t_rows sub_columns(input t_rows s, input logic inv);
        t_rows      o;
        logic [3:0] nib;
        logic [3:0] sb;
        for (int b = 0; b < 32; b++) begin
            nib = {s[0][b], s[1][b], s[2][b], s[3][b]};
            sb  = inv ? SUB_INV[{nib, 2'b00} +: 4] : SUB_FWD[{nib, 2'b00} +: 4];
            o[0][b] = sb[3];
            o[1][b] = sb[2];
            o[2][b] = sb[1];
            o[3][b] = sb[0];
        end
        return o;
    endfunction

    // returns the result word in port layout: result_high low, result_low high
    function automatic logic [127:0] cipher_block(input logic dec, input logic [63:0] hi,
                                                  input logic [63:0] lo, input logic [63:0] khi,
                                                  input logic [63:0] klo);
        t_rows       rk [0:ROUNDS];
        t_rows       s;
        logic [31:0] mix;
        rk[0] = {khi, klo};
        for (int r = 0; r < ROUNDS; r++) begin
            mix = rk[r][0] ^ rk[r][1] ^ rk[r][2] ^ rk[r][3];
            rk[r+1][0] = circ(KEY_COL, rk[r][0] ^ mix) ^ KEY_ADD[0] ^ 32'(r);
            rk[r+1][1] = rot_left(rk[r][1] ^ mix, 8) ^ KEY_ADD[1];
            rk[r+1][2] = rot_left(rk[r][2] ^ mix, 15) ^ KEY_ADD[2];
            rk[r+1][3] = rot_left(rk[r][3] ^ mix, 18) ^ KEY_ADD[3];
        end
        s = {hi, lo};
        if (dec == bsbc_pkg::CMD_ENC) begin
            for (int r = 0; r < ROUNDS; r++) begin
                s = sub_columns(s ^ rk[r], 1'b0);
                for (int i = 0; i < 4; i++) begin
                    s[i] = circ(MIX_FWD[i], s[i]);
                end
            end
            s = s ^ rk[ROUNDS];
        end else begin
            s = s ^ rk[ROUNDS];
            for (int r = ROUNDS - 1; r >= 0; r--) begin
                for (int i = 0; i < 4; i++) begin
                    s[i] = circ(MIX_INV[i], s[i]);
                end
                s = sub_columns(s, 1'b1) ^ rk[r];
            end
        end
        return {s[2], s[3], s[0], s[1]};
    endfunction

    task automatic add_expected(input logic [127:0] w);
        cipher_out_q.insert(cipher_out_q.size(), w);
    endtask

    task automatic report_field(input string name, input logic [63:0] exp_v,
                                input logic [63:0] got_v);
        fail_count = fail_count + 1;
        if (fail_count <= 10) begin
            $display("mismatch %0d at %0t: %s expected %h got %h",
                     fail_count, $realtime, name, exp_v, got_v);
        end
    endtask

    initial begin
        fail_count = 0;
        o_pending  = 0;
        key_hi     = '0;
        key_lo     = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_hi = '0;
            key_lo = '0;
            cipher_out_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == bsbc_pkg::REG_KEY_HIGH) begin
                    key_hi = i_cfg_data;
                end else begin
                    key_lo = i_cfg_data;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                add_expected(cipher_block(i_s_tuser, i_s_tdata[63:0],
                                          i_s_tdata[127:64], key_hi, key_lo));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (cipher_out_q.size() == 0) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= 10) begin
                        $display("mismatch %0d at %0t: unexpected word %h",
                                 fail_count, $realtime, i_m_tdata);
                    end
                end else begin
                    want = cipher_out_q.pop_front();
                    if (want[63:0] !== i_m_tdata[63:0]) begin
                        report_field("result_high", want[63:0], i_m_tdata[63:0]);
                    end
                    if (want[127:64] !== i_m_tdata[127:64]) begin
                        report_field("result_low", want[127:64], i_m_tdata[127:64]);
                    end
                end
            end
        end
        o_pending = cipher_out_q.size();
    end

endmodule

### sim/bitsliced_spn_block_cipher_128_tb.sv
`timescale 1ns / 100ps
module bitsliced_spn_block_cipher_128_tb;

    localparam int LIMIT = 200000;
    localparam logic [12:0] STALL_PAT = 13'b1_0110_0111_0001;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_tvalid;
    logic [127:0] s_tdata;
    logic         s_tuser;
    logic         m_tready;
    logic         cfg_we;
    logic         cfg_idx;
    logic [63:0]  cfg_data;
    wire          s_tready;
    wire          m_tvalid;
    wire  [127:0] m_tdata;

    int fail_count;
    int pending;
    int cycles = 0;
    int burst_left = 0;
    int enc_sent = 0;
    int dec_sent = 0;
    int key_sets = 1;

    bitsliced_spn_block_cipher_128 u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    cipher_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall modes rotate with bits 10:9 of the cycle counter
    always @(negedge i_clk) begin
        case (cycles[10:9])
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= ($urandom_range(3) != 0);
            end
            2'd2: begin
                m_tready <= STALL_PAT[cycles % 13];
            end
            default: begin
                m_tready <= ($urandom_range(3) == 0);
            end
        endcase
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input bsbc_pkg::t_cmd cmd, input logic [63:0] hi,
                             input logic [63:0] lo);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left = burst_left - 1;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {lo, hi};
        do @(posedge i_clk); while (!s_tready);
        if (cmd == bsbc_pkg::CMD_ENC) begin
            enc_sent = enc_sent + 1;
        end else begin
            dec_sent = dec_sent + 1;
        end
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_half();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return 64'h1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic run_random(input int n);
        repeat (n) begin
            send_word(bsbc_pkg::t_cmd'($urandom_range(1)), pick_half(), pick_half());
        end
    endtask

    // waits until the pipeline has drained, then writes both key registers
    task automatic set_key(input logic [63:0] khi, input logic [63:0] klo);
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
        repeat (16) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= bsbc_pkg::REG_KEY_HIGH;
        cfg_data <= khi;
        @(negedge i_clk);
        cfg_idx  <= bsbc_pkg::REG_KEY_LOW;
        cfg_data <= klo;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        key_sets = key_sets + 1;
    endtask

    initial begin
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = bsbc_pkg::CMD_ENC;
        m_tready = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = bsbc_pkg::REG_KEY_HIGH;
        cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset key
        send_word(bsbc_pkg::CMD_ENC, '0, '0);
        send_word(bsbc_pkg::CMD_DEC, '0, '0);
        send_word(bsbc_pkg::CMD_ENC, '1, '1);
        send_word(bsbc_pkg::CMD_DEC, '1, '1);
        send_word(bsbc_pkg::CMD_ENC, 64'h8000_0000_0000_0000, '0);
        send_word(bsbc_pkg::CMD_DEC, 64'h8000_0000_0000_0000, '0);
        send_word(bsbc_pkg::CMD_ENC, '0, 64'h1);
        send_word(bsbc_pkg::CMD_DEC, '0, 64'h1);
        send_word(bsbc_pkg::CMD_ENC, {32{2'b01}}, {32{2'b01}});
        send_word(bsbc_pkg::CMD_DEC, {32{2'b10}}, {32{2'b10}});
        send_word(bsbc_pkg::CMD_ENC, 64'hffff_ffff_0000_0000, 64'h0000_0000_ffff_ffff);
        send_word(bsbc_pkg::CMD_DEC, 64'h0000_0000_ffff_ffff, 64'hffff_ffff_0000_0000);
        run_random(57);

        set_key('1, '1);
        send_word(bsbc_pkg::CMD_ENC, '0, '0);
        send_word(bsbc_pkg::CMD_DEC, '0, '0);
        send_word(bsbc_pkg::CMD_ENC, '1, '1);
        send_word(bsbc_pkg::CMD_DEC, '1, '1);
        run_random(57);

        set_key('0, '1);
        run_random(57);
        set_key({$urandom, $urandom}, {$urandom, $urandom});
        run_random(57);
        set_key(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        run_random(57);
        set_key({$urandom, $urandom}, {$urandom, $urandom});
        run_random(57);
        set_key('0, '0);
        run_random(57);

        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (30) @(negedge i_clk);

        $display("%0d blocks encrypted and %0d decrypted under %0d key settings",
                 enc_sent, dec_sent, key_sets);
        $display("bursty input with gaps, output stalls in four rotating modes");
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
